### design/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// Used by cbm_mod_unit and cartridge_bank_mapper; depends on nothing else.
package cbm_pkg;

  localparam int unsigned PageBits = 8;  // widest page value before reduction
  localparam int unsigned DivBits  = 12; // widest page count

  localparam logic [15:0] ADDR_MASK = 16'h4101;
  localparam logic [15:0] ADDR_CMD  = 16'h4100;
  localparam logic [15:0] ADDR_REG  = 16'h4101;

  localparam logic [2:0] CMD_CHR_LOW_A  = 3'd0;
  localparam logic [2:0] CMD_CHR_HIGH_A = 3'd1;
  localparam logic [2:0] CMD_CHR_LOW_B  = 3'd2;
  localparam logic [2:0] CMD_CHR_HIGH_B = 3'd3;
  localparam logic [2:0] CMD_CHR_OUTER  = 3'd4;
  localparam logic [2:0] CMD_PRG        = 3'd5;
  localparam logic [2:0] CMD_MIRROR     = 3'd7;

  localparam logic [1:0] KIND_CHR    = 2'd0;
  localparam logic [1:0] KIND_PRG    = 2'd1;
  localparam logic [1:0] KIND_MIRROR = 2'd2;

  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_CHR_COUNT = 1'b1;

  localparam logic [2:0] CHR_LAST_SLOT = 3'd7;
  localparam logic [2:0] PRG_LAST_SLOT = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  update_kind;
    logic [2:0]  slot_index;
    logic [10:0] page_number;
    logic [1:0]  mirror_code;
    logic        last_update;
  } out_beat_t;

  typedef struct packed {
    logic                start;
    logic [PageBits-1:0] dividend;
    logic [DivBits-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [PageBits-1:0] remainder;
  } mod_rsp_t;

endpackage

### design/cbm_mod_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on cbm_pkg for the request and response structs.
module cbm_mod_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbm_pkg::mod_req_t req_i,
  output cbm_pkg::mod_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [2:0]                   cnt_q, cnt_d;
  logic [cbm_pkg::PageBits-1:0] dvd_q, dvd_d;
  logic [cbm_pkg::PageBits-1:0] rem_q, rem_d;
  logic [cbm_pkg::DivBits-1:0]  div_q, div_d;
  logic [cbm_pkg::PageBits:0]   trial;
  logic [cbm_pkg::PageBits:0]   diff;

  // The partial remainder never exceeds the dividend prefix, so nine bits suffice.
  assign trial = {rem_q, dvd_q[cbm_pkg::PageBits-1]};
  assign diff  = trial - div_q[cbm_pkg::PageBits:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[cbm_pkg::PageBits-2:0], 1'b0};
      if ({{(cbm_pkg::DivBits-cbm_pkg::PageBits-1){1'b0}}, trial} >= div_q) begin
        rem_d = diff[cbm_pkg::PageBits-1:0];
      end else begin
        rem_d = trial[cbm_pkg::PageBits-1:0];
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // A zero count maps every page to page zero.
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = (div_q == '0) ? '0 : rem_q;

endmodule

### design/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: CPU write decode, bank registers and sequencer.
// Depends on cbm_pkg and instantiates cbm_mod_unit for the page reductions.
//
//   Channel  Direction  Signals                                 Beat
//   in       input      in_valid_i, in_stall_o, in_data_i       one CPU bus write
//   out      output     out_valid_o, out_stall_i, out_data_o    one page or mirroring update
//   cfg      input      cfg_we_i, cfg_index_i, cfg_data_i       one page count write
//
// A command write, a register write that changes nothing visible, or an unmatched address
// is taken and gives no update. A mirroring write gives a single update from the output
// register, held there while the output stalls. Each character or program update starts the
// shared remainder unit, runs its one-bit-a-cycle restoring steps, waits for its done flag and
// then sits in the output register until taken, so a character write gives eight updates and
// a program write four.
// Reset is asynchronous and active low; the input is stalled until the last update has gone.
module cartridge_bank_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbm_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbm_pkg::out_beat_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  cbm_pkg::state_e   state_q, state_d;
  cbm_pkg::mod_req_t mod_req;
  cbm_pkg::mod_rsp_t mod_rsp;
  cbm_pkg::out_beat_t out_q;

  logic [9:0]  prg_count_q;
  logic [11:0] chr_count_q;
  logic [2:0]  cmd_q;
  logic [2:0]  chr_low_a_q, chr_high_a_q, chr_low_b_q, chr_high_b_q, chr_outer_q;
  logic [2:0]  prg_bank_q;
  logic [1:0]  kind_q;
  logic [2:0]  slot_q;

  logic        in_fire, out_fire;
  logic [15:0] sel_addr;
  logic [2:0]  d3;
  logic        is_cmd_write, is_reg_write;
  logic        go_chr, go_prg, go_mirror;
  logic [2:0]  chr_reg;
  logic [cbm_pkg::PageBits-1:0] dividend;
  logic        slot_is_last;
  logic [1:0]  mirror_code;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  assign sel_addr     = in_data_i.bus_addr & cbm_pkg::ADDR_MASK;
  assign d3           = in_data_i.bus_data[2:0];
  assign is_cmd_write = (sel_addr == cbm_pkg::ADDR_CMD);
  assign is_reg_write = (sel_addr == cbm_pkg::ADDR_REG);

  // Commands 0 to 4 all re-report the eight character slots.
  assign go_chr    = in_fire && is_reg_write && (cmd_q <= cbm_pkg::CMD_CHR_OUTER);
  assign go_prg    = in_fire && is_reg_write && (cmd_q == cbm_pkg::CMD_PRG);
  assign go_mirror = in_fire && is_reg_write && (cmd_q == cbm_pkg::CMD_MIRROR);

  // Each pair of character slots takes its bank from one of the four A and B low and high registers.
  always_comb begin
    case (slot_q[2:1])
      2'd0:    chr_reg = chr_low_a_q;
      2'd1:    chr_reg = chr_high_a_q;
      2'd2:    chr_reg = chr_low_b_q;
      default: chr_reg = chr_high_b_q;
    endcase
  end

  // The character page is the outer bits, the slot's register and the two low slot bits.
  always_comb begin
    if (kind_q == cbm_pkg::KIND_CHR) begin
      dividend = {chr_outer_q, chr_reg, slot_q[1], slot_q[0]};
    end else begin
      dividend = {3'b000, prg_bank_q, slot_q[1:0]};
    end
  end

  assign slot_is_last = (kind_q == cbm_pkg::KIND_CHR) ? (slot_q == cbm_pkg::CHR_LAST_SLOT)
                                                      : (slot_q == cbm_pkg::PRG_LAST_SLOT);

  // Data bits two and one pick the mirroring: 0 and 3 give code 2, 1 gives 0, 2 gives 1.
  always_comb begin
    case (in_data_i.bus_data[2:1])
      2'd0:    mirror_code = 2'd2;
      2'd1:    mirror_code = 2'd0;
      2'd2:    mirror_code = 2'd1;
      default: mirror_code = 2'd2;
    endcase
  end

  assign mod_req.start    = (state_q == cbm_pkg::ST_LOAD);
  assign mod_req.dividend = dividend;
  assign mod_req.divisor  = (kind_q == cbm_pkg::KIND_CHR) ? chr_count_q
                                                           : {2'b00, prg_count_q};

  cbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbm_pkg::ST_IDLE: begin
        if (go_chr || go_prg) begin
          state_d = cbm_pkg::ST_LOAD;
        end else if (go_mirror) begin
          state_d = cbm_pkg::ST_OUT;
        end
      end
      cbm_pkg::ST_LOAD: state_d = cbm_pkg::ST_CALC;
      cbm_pkg::ST_CALC: begin
        if (mod_rsp.done) begin
          state_d = cbm_pkg::ST_OUT;
        end
      end
      cbm_pkg::ST_OUT: begin
        if (out_fire) begin
          state_d = out_q.last_update ? cbm_pkg::ST_IDLE : cbm_pkg::ST_LOAD;
        end
      end
      default: state_d = cbm_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      cbm_pkg::ST_IDLE: in_stall_o  = 1'b0;
      cbm_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cbm_pkg::ST_IDLE;
      prg_count_q  <= 10'd2;
      chr_count_q  <= 12'd8;
      cmd_q        <= '0;
      chr_low_a_q  <= '0;
      chr_high_a_q <= '0;
      chr_low_b_q  <= '0;
      chr_high_b_q <= '0;
      chr_outer_q  <= '0;
      kind_q       <= cbm_pkg::KIND_CHR;
      slot_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          cbm_pkg::REG_PRG_COUNT: prg_count_q <= cfg_data_i[9:0];
          cbm_pkg::REG_CHR_COUNT: chr_count_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_fire && is_cmd_write) begin
        cmd_q <= d3;
      end

      if (go_chr) begin
        case (cmd_q)
          cbm_pkg::CMD_CHR_LOW_A:  chr_low_a_q  <= d3;
          cbm_pkg::CMD_CHR_HIGH_A: chr_high_a_q <= d3;
          cbm_pkg::CMD_CHR_LOW_B:  chr_low_b_q  <= d3;
          cbm_pkg::CMD_CHR_HIGH_B: chr_high_b_q <= d3;
          default:                 chr_outer_q  <= d3;
        endcase
        kind_q <= cbm_pkg::KIND_CHR;
        slot_q <= '0;
      end else if (go_prg) begin
        kind_q <= cbm_pkg::KIND_PRG;
        slot_q <= '0;
      end else if (go_mirror) begin
        kind_q <= cbm_pkg::KIND_MIRROR;
        slot_q <= '0;
      end else if (out_fire && !out_q.last_update) begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  // Payload registers: the program bank and the output beat.
  always_ff @(posedge clk_i) begin
    if (go_prg) begin
      prg_bank_q <= d3;
    end
    if (go_mirror) begin
      out_q.update_kind <= cbm_pkg::KIND_MIRROR;
      out_q.slot_index  <= '0;
      out_q.page_number <= '0;
      out_q.mirror_code <= mirror_code;
      out_q.last_update <= 1'b1;
    end else if (state_q == cbm_pkg::ST_CALC && mod_rsp.done) begin
      out_q.update_kind <= kind_q;
      out_q.slot_index  <= slot_q;
      out_q.page_number <= {3'b000, mod_rsp.remainder};
      out_q.mirror_code <= '0;
      out_q.last_update <= slot_is_last;
    end
  end

`ifndef SYNTH
  // No new write is taken while an update is still on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input accepted while an update is pending");

  // The remainder unit only finishes while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == cbm_pkg::ST_CALC))
    else $error("remainder unit finished outside the calculation state");

  // After the final update of a write has gone, the output falls idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.last_update) |=> !out_valid_o)
    else $error("update offered after the last one of a write");

  // Program updates cover only the four program slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.update_kind == cbm_pkg::KIND_PRG)
      |-> !out_data_o.slot_index[2])
    else $error("program update with a slot beyond the fourth");
`endif

endmodule
